/* rtl/core/fbpa_pkg.sv */
// Shared types, codes and sizes for the fixed block pool allocator.
package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF = 256;

    localparam int DATA_W     = 32;
    localparam int RAW_W      = 13;
    localparam int POOL_W     = 9;
    localparam int OP_W       = 2;
    localparam int ST_W       = 2;
    localparam int FREE_W     = 9;
    localparam int CFG_IDX_W  = 2;
    // Block size in units of 8 bytes: at most 1024.
    localparam int SIZE8_W    = 11;
    // Dividend is the byte offset divided by 8, padded to an even bit count.
    localparam int DIV_W      = 30;
    localparam int DIV_STEPS  = DIV_W / 2;
    localparam int DIV_STEP_W = 4;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_ADDR = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ALLOC_MUL,
        S_ALLOC_ADD,
        S_DIV,
        S_FREE_CHK,
        S_INIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic alloc_rd;
        logic mul_load;
        logic add_load;
        logic set_empty;
        logic set_bad;
        logic div_start;
        logic div_step;
        logic free_commit;
        logic init_start;
        logic init_step;
        logic init_finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            top_zero;
        logic            addr_low;
        logic            div_last;
        logic            init_done;
        logic            out_free;
    } t_sts;

endpackage

/* rtl/core/fbpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/fbpa_ctrl.sv */
// Controller state machine of the block pool allocator.
module fbpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fbpa_pkg::t_sts i_sts,
    output fbpa_pkg::t_cmd o_cmd
);

    fbpa_pkg::t_state r_state;
    fbpa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            fbpa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = fbpa_pkg::S_DISPATCH;
                end
            end
            fbpa_pkg::S_DISPATCH: begin
                unique case (i_sts.op)
                    fbpa_pkg::OP_ALLOC: begin
                        if (i_sts.top_zero) begin
                            o_cmd.set_empty = 1'b1;
                            n_state         = fbpa_pkg::S_FINISH;
                        end else begin
                            o_cmd.alloc_rd = 1'b1;
                            n_state        = fbpa_pkg::S_ALLOC_MUL;
                        end
                    end
                    fbpa_pkg::OP_FREE: begin
                        if (i_sts.addr_low) begin
                            o_cmd.set_bad = 1'b1;
                            n_state       = fbpa_pkg::S_FINISH;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = fbpa_pkg::S_DIV;
                        end
                    end
                    fbpa_pkg::OP_INIT: begin
                        o_cmd.init_start = 1'b1;
                        n_state          = fbpa_pkg::S_INIT;
                    end
                    default: begin
                        n_state = fbpa_pkg::S_FINISH;
                    end
                endcase
            end
            fbpa_pkg::S_ALLOC_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = fbpa_pkg::S_ALLOC_ADD;
            end
            fbpa_pkg::S_ALLOC_ADD: begin
                o_cmd.add_load = 1'b1;
                n_state        = fbpa_pkg::S_FINISH;
            end
            fbpa_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = fbpa_pkg::S_FREE_CHK;
                end
            end
            fbpa_pkg::S_FREE_CHK: begin
                o_cmd.free_commit = 1'b1;
                n_state           = fbpa_pkg::S_FINISH;
            end
            fbpa_pkg::S_INIT: begin
                if (i_sts.init_done) begin
                    o_cmd.init_finish = 1'b1;
                    n_state           = fbpa_pkg::S_FINISH;
                end else begin
                    o_cmd.init_step = 1'b1;
                end
            end
            fbpa_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = fbpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fbpa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/fbpa_dp.sv */
// Datapath of the block pool allocator: registers, free stack, divider and result register.
module fbpa_dp #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbpa_pkg::DATA_W-1:0]      i_cfg_data,
    input  logic [fbpa_pkg::OP_W-1:0]        i_opcode,
    input  logic [fbpa_pkg::DATA_W-1:0]      i_free_address,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [fbpa_pkg::DATA_W-1:0]      o_block_address,
    output logic [fbpa_pkg::ST_W-1:0]        o_status,
    output logic [fbpa_pkg::FREE_W-1:0]      o_free_blocks,
    input  fbpa_pkg::t_cmd                   i_cmd,
    output fbpa_pkg::t_sts                   o_sts
);

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int TOP_W  = $clog2(MAX_BLOCKS + 1);
    localparam int PROD_W = IDX_W + fbpa_pkg::SIZE8_W;

    // Configuration registers.
    logic [fbpa_pkg::DATA_W-1:0] r_base;
    logic [fbpa_pkg::RAW_W-1:0]  r_raw;
    logic [fbpa_pkg::POOL_W-1:0] r_pool;

    // Request and working registers.
    logic [fbpa_pkg::OP_W-1:0]       r_op;
    logic [fbpa_pkg::DATA_W-1:0]     r_addr;
    logic [TOP_W-1:0]                r_top;
    logic [TOP_W-1:0]                r_icnt;
    logic [fbpa_pkg::DIV_W-1:0]      r_dq;
    logic [fbpa_pkg::SIZE8_W-1:0]    r_rem;
    logic [fbpa_pkg::DIV_STEP_W-1:0] r_dstep;
    logic [PROD_W-1:0]               r_prod;
    logic [fbpa_pkg::DATA_W-1:0]     r_res_addr;
    logic [fbpa_pkg::ST_W-1:0]       r_res_status;

    // Result register.
    logic                        r_out_valid;
    logic [fbpa_pkg::DATA_W-1:0] r_out_addr;
    logic [fbpa_pkg::ST_W-1:0]   r_out_status;
    logic [fbpa_pkg::FREE_W-1:0] r_out_free;

    logic [fbpa_pkg::RAW_W:0]     raw_p7;
    logic [fbpa_pkg::SIZE8_W-1:0] size8_raw;
    logic [fbpa_pkg::SIZE8_W-1:0] size8;
    logic [TOP_W-1:0]             count;
    logic [TOP_W-1:0]             top_m1;
    logic [fbpa_pkg::DATA_W-1:0]  offset;
    logic [fbpa_pkg::SIZE8_W:0]   t_hi;
    logic [fbpa_pkg::SIZE8_W:0]   t_lo;
    logic [fbpa_pkg::SIZE8_W-1:0] rem_mid;
    logic [fbpa_pkg::SIZE8_W-1:0] rem_end;
    logic                         q_hi;
    logic                         q_lo;
    logic                         idx_bad;
    logic                         stack_full;
    logic                         push;
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [IDX_W-1:0]             ram_wdata;
    logic [IDX_W-1:0]             ram_rdata;

    // Size in 8-byte units; a zero size counts as one unit.
    assign raw_p7    = {1'b0, r_raw} + (fbpa_pkg::RAW_W + 1)'(7);
    assign size8_raw = raw_p7[fbpa_pkg::RAW_W:3];
    assign size8     = (size8_raw == '0) ? fbpa_pkg::SIZE8_W'(1) : size8_raw;

    assign count  = (32'(r_pool) > 32'(MAX_BLOCKS)) ? TOP_W'(MAX_BLOCKS) : TOP_W'(r_pool);
    assign top_m1 = r_top - TOP_W'(1);
    assign offset = r_addr - r_base;

    // Two restoring division steps per cycle.
    always_comb begin
        t_hi    = {r_rem, r_dq[fbpa_pkg::DIV_W-1]};
        q_hi    = (t_hi >= {1'b0, size8});
        rem_mid = q_hi ? fbpa_pkg::SIZE8_W'(t_hi - {1'b0, size8})
                       : t_hi[fbpa_pkg::SIZE8_W-1:0];
        t_lo    = {rem_mid, r_dq[fbpa_pkg::DIV_W-2]};
        q_lo    = (t_lo >= {1'b0, size8});
        rem_end = q_lo ? fbpa_pkg::SIZE8_W'(t_lo - {1'b0, size8})
                       : t_lo[fbpa_pkg::SIZE8_W-1:0];
    end

    assign idx_bad    = (r_dq >= fbpa_pkg::DIV_W'(count));
    assign stack_full = (r_top >= count);
    assign push       = i_cmd.free_commit && !idx_bad && !stack_full;

    assign ram_we    = i_cmd.init_step || push;
    assign ram_waddr = i_cmd.init_step ? r_icnt[IDX_W-1:0] : r_top[IDX_W-1:0];
    assign ram_wdata = i_cmd.init_step ? r_icnt[IDX_W-1:0] : r_dq[IDX_W-1:0];

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.alloc_rd),
        .i_raddr (top_m1[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_raw       <= fbpa_pkg::RAW_W'(8);
            r_pool      <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fbpa_pkg::CFG_BASE: r_base <= i_cfg_data;
                    fbpa_pkg::CFG_RAW:  r_raw  <= i_cfg_data[fbpa_pkg::RAW_W-1:0];
                    fbpa_pkg::CFG_POOL: r_pool <= i_cfg_data[fbpa_pkg::POOL_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.alloc_rd) begin
                r_top <= top_m1;
            end else if (push) begin
                r_top <= r_top + TOP_W'(1);
            end else if (i_cmd.init_finish) begin
                r_top <= count;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op         <= i_opcode;
            r_addr       <= i_free_address;
            r_res_addr   <= '0;
            r_res_status <= fbpa_pkg::ST_OK;
        end
        if (i_cmd.set_empty) begin
            r_res_status <= fbpa_pkg::ST_EMPTY;
        end
        if (i_cmd.set_bad) begin
            r_res_status <= fbpa_pkg::ST_BAD_ADDR;
        end
        if (i_cmd.mul_load) begin
            r_prod <= PROD_W'(ram_rdata) * PROD_W'(size8);
        end
        if (i_cmd.add_load) begin
            r_res_addr <= r_base + fbpa_pkg::DATA_W'({r_prod, 3'b000});
        end
        if (i_cmd.div_start) begin
            r_dq    <= fbpa_pkg::DIV_W'(offset[fbpa_pkg::DATA_W-1:3]);
            r_rem   <= '0;
            r_dstep <= '0;
        end else if (i_cmd.div_step) begin
            r_dq    <= {r_dq[fbpa_pkg::DIV_W-3:0], q_hi, q_lo};
            r_rem   <= rem_end;
            r_dstep <= r_dstep + fbpa_pkg::DIV_STEP_W'(1);
        end
        if (i_cmd.free_commit) begin
            if (idx_bad) begin
                r_res_status <= fbpa_pkg::ST_BAD_ADDR;
            end else if (stack_full) begin
                r_res_status <= fbpa_pkg::ST_FULL;
            end
        end
        if (i_cmd.init_start) begin
            r_icnt <= '0;
        end else if (i_cmd.init_step) begin
            r_icnt <= r_icnt + TOP_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
            r_out_free   <= fbpa_pkg::FREE_W'(r_top);
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.top_zero  = (r_top == '0);
    assign o_sts.addr_low  = (r_addr < r_base);
    assign o_sts.div_last  = (r_dstep == fbpa_pkg::DIV_STEP_W'(fbpa_pkg::DIV_STEPS - 1));
    assign o_sts.init_done = (r_icnt == count);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_block_address = r_out_addr;
    assign o_status        = r_out_status;
    assign o_free_blocks   = r_out_free;

endmodule

/* rtl/core/fixed_block_pool_allocator_top.sv */
// Top level of the fixed block pool allocator: controller, datapath and checks.
//
//  Channel   Direction  Handshake                  Payload
//  ------    ---------  -------------------------  ------------------------------------
//  request   in         i_in_valid / o_in_ready    i_opcode, i_free_address
//  result    out        o_out_valid / i_out_ready  o_block_address, o_status, o_free_blocks
//  config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// One request is worked on at a time. An allocation does one stack read, one multiply
// and one add. A free runs the divider, which retires two quotient bits a cycle over 30
// bits. An initialize does one stack write per block index. Reset is synchronous and
// active low; it clears the stack top, the base and pool registers and the result valid
// flag and sets the raw size to 8, but it leaves the working registers and the stack
// memory alone, so no clearing pass is needed. A stalled result waits in the output
// register while the next request is already accepted and worked on.
module fixed_block_pool_allocator_top #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fbpa_pkg::DATA_W-1:0]    i_cfg_data,
    // Request channel.
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [fbpa_pkg::OP_W-1:0]      i_opcode,
    input  logic [fbpa_pkg::DATA_W-1:0]    i_free_address,
    // Result channel.
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [fbpa_pkg::DATA_W-1:0]    o_block_address,
    output logic [fbpa_pkg::ST_W-1:0]      o_status,
    output logic [fbpa_pkg::FREE_W-1:0]    o_free_blocks
);

    fbpa_pkg::t_cmd cmd;
    fbpa_pkg::t_sts sts;

    // The controller sequences each request; the datapath holds all state that it touches.
    fbpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fbpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_free_address  (i_free_address),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_block_address (o_block_address),
        .o_status        (o_status),
        .o_free_blocks   (o_free_blocks),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

    // A request is taken once and the controller then leaves its idle state.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted twice in a row");

    // Only a successful allocation reports a nonzero block address.
    a_addr_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != fbpa_pkg::ST_OK)) |-> (o_block_address == '0))
        else $error("failed request carries a block address");

    // An empty pool report means the stack really was empty.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == fbpa_pkg::ST_EMPTY)) |-> (o_free_blocks == '0))
        else $error("pool empty reported with free blocks left");

endmodule

/* tb/sv/fbpa_reply_checker.sv */
// Reply checker for the fixed block pool allocator: tracks the free stack and checks replies.
`timescale 1ns / 1ps
module fbpa_reply_checker
    import fbpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [DATA_W-1:0]    i_free_address,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [DATA_W-1:0]    i_block_address,
    input  logic [ST_W-1:0]      i_status,
    input  logic [FREE_W-1:0]    i_free_blocks,
    output int                   o_fault_count,
    output int                   o_replies_owed
);

    localparam int STACK_DEPTH = MAX_BLOCKS_DEF;
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    typedef struct packed {
        logic [DATA_W-1:0] block_address;
        logic [ST_W-1:0]   status;
        logic [FREE_W-1:0] free_blocks;
    } t_pool_reply;

    // Shadow copies of the pool registers and the free stack.
    logic [DATA_W-1:0] base_q;
    logic [RAW_W-1:0]  raw_q;
    logic [POOL_W-1:0] pool_q;
    logic [IDX_W-1:0]  free_stack [STACK_DEPTH];
    logic [FREE_W-1:0] stack_top;

    t_pool_reply replies [$];
    int          faults = 0;

    // Applies one request to the shadow pool and returns the reply it must produce.
    task automatic serve_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] addr,
                                 output t_pool_reply reply);
        logic [DATA_W-1:0] bytes;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] idx;
        bytes = (DATA_W'(raw_q) + 32'd7) & ~32'd7;
        if (bytes == '0) begin
            bytes = 32'd8;
        end
        count = (pool_q > STACK_DEPTH) ? DATA_W'(STACK_DEPTH) : DATA_W'(pool_q);
        reply = '{'0, ST_OK, '0};
        case (op)
            OP_ALLOC: begin
                if (stack_top == '0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    stack_top = stack_top - 1'b1;
                    reply.block_address =
                        base_q + DATA_W'(free_stack[stack_top % STACK_DEPTH]) * bytes;
                end
            end
            OP_FREE: begin
                if (addr < base_q) begin
                    reply.status = ST_BAD_ADDR;
                end else begin
                    idx = (addr - base_q) / bytes;
                    if (idx >= count) begin
                        reply.status = ST_BAD_ADDR;
                    end else if (DATA_W'(stack_top) >= count) begin
                        reply.status = ST_FULL;
                    end else begin
                        free_stack[stack_top % STACK_DEPTH] = IDX_W'(idx);
                        stack_top = stack_top + 1'b1;
                    end
                end
            end
            OP_INIT: begin
                for (int i = 0; i < count; i++) begin
                    free_stack[i] = IDX_W'(i);
                end
                stack_top = FREE_W'(count);
            end
            default: ;
        endcase
        reply.free_blocks = stack_top;
    endtask

    always @(posedge i_clk) begin : watch
        t_pool_reply want;
        t_pool_reply got;
        if (!i_rst_n) begin
            base_q    = '0;
            raw_q     = RAW_W'(8);
            pool_q    = '0;
            stack_top = '0;
            replies.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE: base_q = i_cfg_data;
                    CFG_RAW:  raw_q  = i_cfg_data[RAW_W-1:0];
                    CFG_POOL: pool_q = i_cfg_data[POOL_W-1:0];
                    default: ;
                endcase
            end
            // A reply leaving now belongs to a request taken at an earlier edge.
            if (i_out_valid && i_out_ready) begin
                got = '{i_block_address, i_status, i_free_blocks};
                if (replies.size() == 0) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("%0t: reply with none pending: addr %h status %0d free %0d",
                                 $time, got.block_address, got.status, got.free_blocks);
                    end
                end else begin
                    want = replies.pop_front();
                    if (got.block_address !== want.block_address ||
                        got.status !== want.status ||
                        got.free_blocks !== want.free_blocks) begin
                        faults++;
                        if (faults <= 10) begin
                            $display("%0t: reply mismatch: expected addr %h status %0d free %0d,",
                                     $time, want.block_address, want.status,
                                     want.free_blocks,
                                     " got addr %h status %0d free %0d",
                                     got.block_address, got.status, got.free_blocks);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                serve_request(i_opcode, i_free_address, want);
                replies.push_back(want);
            end
        end
        o_fault_count  <= faults;
        o_replies_owed <= replies.size();
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the fixed block pool allocator: clock, reset, requests and verdict.
`timescale 1ns / 1ps
module tb;
    import fbpa_pkg::*;

    // Opcode 3 has no meaning in the block; it must answer ok and change nothing.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int              DEPTH     = MAX_BLOCKS_DEF;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_opcode;
    logic [DATA_W-1:0]    i_free_address;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [DATA_W-1:0]    o_block_address;
    logic [ST_W-1:0]      o_status;
    logic [FREE_W-1:0]    o_free_blocks;

    int fault_count;
    int replies_owed;

    // Percent chance per cycle that the sender holds back or the receiver stalls.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // The pool settings currently programmed, used to aim free requests at real blocks.
    logic [DATA_W-1:0] base_cfg;
    logic [RAW_W-1:0]  raw_cfg;
    logic [POOL_W-1:0] pool_cfg;

    fixed_block_pool_allocator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_free_address  (i_free_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_block_address (o_block_address),
        .o_status        (o_status),
        .o_free_blocks   (o_free_blocks)
    );

    // The checker sits beside the block, predicts every reply and counts faults.
    fbpa_reply_checker reply_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_free_address  (i_free_address),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_block_address (o_block_address),
        .i_status        (o_status),
        .i_free_blocks   (o_free_blocks),
        .o_fault_count   (fault_count),
        .o_replies_owed  (replies_owed)
    );

    always #4 i_clk = ~i_clk;

    // The receiver decides afresh at every edge whether it takes a reply.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Writes all three pool registers on consecutive edges. Only called while idle.
    task automatic program_pool(input logic [DATA_W-1:0] base, input logic [RAW_W-1:0] raw,
                                input logic [POOL_W-1:0] pool);
        base_cfg = base;
        raw_cfg  = raw;
        pool_cfg = pool;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        i_cfg_index <= CFG_RAW;
        i_cfg_data  <= DATA_W'(raw);
        @(posedge i_clk);
        i_cfg_index <= CFG_POOL;
        i_cfg_data  <= DATA_W'(pool);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Presents one request and returns at the edge that accepts it. Valid is only
    // lowered when the sender chooses to idle, so back-to-back requests keep it high.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] addr);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_free_address <= addr;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Holds the sender back until every reply has come out. The owed count is
    // registered by the checker, so it may be read late but never early.
    task automatic wait_for_replies();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (replies_owed != 0);
    endtask

    // One random request. Most frees target a block of the current pool, sometimes
    // one past the end, at a random byte inside it; the rest are below base or noise.
    task automatic random_request();
        logic [DATA_W-1:0] bytes;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] addr;
        int                pick;
        bytes = (DATA_W'(raw_cfg) + 32'd7) & ~32'd7;
        if (bytes == '0) begin
            bytes = 32'd8;
        end
        count = (pool_cfg > DEPTH) ? DATA_W'(DEPTH) : DATA_W'(pool_cfg);
        pick  = $urandom_range(0, 99);
        if (pick < 40) begin
            send_request(OP_ALLOC, $urandom);
        end else if (pick < 80) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                addr = base_cfg + DATA_W'($urandom_range(0, count)) * bytes
                       + DATA_W'($urandom_range(0, bytes - 1));
            end else if (pick < 85 && base_cfg != '0) begin
                addr = $urandom_range(0, base_cfg - 1);
            end else begin
                addr = $urandom;
            end
            send_request(OP_FREE, addr);
        end else if (pick < 93) begin
            send_request(OP_INIT, $urandom);
        end else begin
            send_request(OP_UNUSED, $urandom);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_BASE;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_ALLOC;
        i_free_address = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first setting: a zero raw size must behave as 8 bytes, and
        // a three block pool makes the empty and full cases quick to reach.
        program_pool(32'h0000_1000, '0, 9'd3);
        send_request(OP_ALLOC, 32'hFFFF_FFFF);   // nothing on the stack yet
        send_request(OP_UNUSED, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'h0000_0000);    // below base
        send_request(OP_INIT, 32'h0000_0000);
        send_request(OP_FREE, 32'h0000_1000);    // valid block, but the stack is full
        send_request(OP_FREE, 32'h0000_1018);    // first block past the pool
        send_request(OP_FREE, 32'hFFFF_FFFF);    // huge index
        send_request(OP_ALLOC, 32'h0000_0000);
        send_request(OP_ALLOC, 32'h0000_0000);
        send_request(OP_ALLOC, 32'h0000_0000);
        send_request(OP_ALLOC, 32'h0000_0000);   // drained empty
        send_request(OP_FREE, 32'h0000_100D);    // unaligned, frees block 1
        send_request(OP_FREE, 32'h0000_1017);    // last byte of block 2
        send_request(OP_ALLOC, 32'h0000_0000);
        send_request(OP_FREE, 32'h0000_0FFF);    // one byte below base
        wait_for_replies();

        // Second setting: the largest size, a count above the stack depth and a base
        // near the top of the address space, so block addresses wrap past zero.
        program_pool(32'hFFFF_F000, 13'd8191, 9'd511);
        send_request(OP_INIT, 32'h0000_0000);
        send_request(OP_ALLOC, 32'h0000_0000);   // last block, address wraps
        send_request(OP_FREE, 32'h001F_D000);    // that wrapped address is below base
        send_request(OP_FREE, 32'hFFFF_FFFF);    // inside block 0
        send_request(OP_FREE, 32'hFFFF_FFFF);    // stack full again
        send_request(OP_UNUSED, 32'h0000_0000);
        send_request(OP_ALLOC, 32'h0000_0000);
        send_request(OP_ALLOC, 32'h0000_0000);
        wait_for_replies();

        // Random part. Each phase picks a pool setting and an idling pattern; the
        // stack carries over, so a smaller count often follows a full one.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin
                    send_idle_pct <= 0;
                    stall_pct     <= 0;
                end
                1: begin
                    send_idle_pct <= 82;
                    stall_pct     <= 0;
                end
                2: begin
                    send_idle_pct <= 0;
                    stall_pct     <= 82;
                end
                default: begin
                    send_idle_pct <= 14;
                    stall_pct     <= 14;
                end
            endcase
            case (phase)
                0: program_pool(32'h0000_0000, 13'd1, 9'd1);
                1: program_pool(32'hFFFF_FFF8, 13'd8191, 9'd2);
                2: program_pool(32'h0000_0000, 13'd4096, 9'd256);
                3: program_pool($urandom, RAW_W'($urandom_range(0, 8191)), 9'd0);
                default: program_pool($urandom, RAW_W'($urandom_range(0, 64)),
                                      POOL_W'($urandom_range(1, 16)));
            endcase
            if ($urandom_range(0, 1) == 1) begin
                send_request(OP_INIT, $urandom);
            end
            for (int n = 0; n < 50; n++) begin
                // Halfway through, let the block run completely dry once per phase.
                if (n == 25) begin
                    wait_for_replies();
                end
                random_request();
            end
            wait_for_replies();
        end

        // Every request gives exactly one reply, so a short quiet spell is enough to
        // catch a stray extra reply.
        repeat (40) @(posedge i_clk);
        if (fault_count == 0 && replies_owed == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, even with every init at full count.
    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
